/* design/union_find_engine_unit_defines.svh */
// ----------------------------------------------------------------------------
// Union-find engine assertion macros
// Shared concurrent assertion forms used by the engine datapath.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_ENGINE_UNIT_DEFINES_SVH
`define UNION_FIND_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ufe_pkg.sv */
// ----------------------------------------------------------------------------
// Union-find engine package
// Sizes, beat layouts, controller states and controller/datapath interface.
// ----------------------------------------------------------------------------
package ufe_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int INDEX_W      = $clog2(MAX_ELEMENTS);
	localparam int COUNT_W      = INDEX_W + 1;
	localparam int CFG_W        = INDEX_W + 1;
	localparam int S_TDATA_W    = ((2 * INDEX_W + 7) / 8) * 8;
	localparam int M_TDATA_W    = ((INDEX_W + COUNT_W + 1 + 7) / 8) * 8;

	localparam logic OP_FIND  = 1'b0;
	localparam logic OP_UNITE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_COMP,
		ST_SZA,
		ST_SZB,
		ST_COMMIT,
		ST_ERROR
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_WALK_START,
		DP_WALK_STEP,
		DP_COMP_START,
		DP_COMP_STEP,
		DP_SIZE_A,
		DP_SIZE_B,
		DP_SIZE_CAP,
		DP_COMMIT,
		DP_ERROR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sel_b;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic is_unite;
		logic root_found;
		logic comp_done;
		logic out_busy;
	} dp_stat_t;

endpackage

/* design/ufe_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (read-old on collision).
// ----------------------------------------------------------------------------
module ufe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/ufe_ctrl.sv */
// ----------------------------------------------------------------------------
// Union-find engine controller
// Sequences clear sweep, root walks, path compression, size reads and commit or error.
// ----------------------------------------------------------------------------
module ufe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ufe_pkg::dp_stat_t stat,
	output ufe_pkg::dp_cmd_t  cmd
);
	import ufe_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) begin
				sel_q <= 1'b0;
			end else if (state_q == ST_COMP && stat.comp_done && !sel_q && stat.is_unite) begin
				sel_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (stat.clear_last) state_d = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_d = ST_CHECK;
			ST_CHECK:  state_d = stat.in_range ? ST_WALK : ST_ERROR;
			ST_WALK:   if (stat.root_found) state_d = ST_COMP;
			ST_COMP: begin
				if (stat.comp_done) begin
					state_d = (!sel_q && stat.is_unite) ? ST_WALK : ST_SZA;
				end
			end
			ST_SZA:    state_d = ST_SZB;
			ST_SZB:    state_d = ST_COMMIT;
			ST_COMMIT: if (!stat.out_busy) state_d = ST_IDLE;
			ST_ERROR:  if (!stat.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = DP_NOP;
		cmd.sel_b = sel_q;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.op = DP_CLEAR;
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd.op = DP_LOAD;
			end
			ST_CHECK: begin
				cmd.sel_b = 1'b0;
				if (stat.in_range) cmd.op = DP_WALK_START;
			end
			ST_WALK:  cmd.op = stat.root_found ? DP_COMP_START : DP_WALK_STEP;
			ST_COMP: begin
				if (!stat.comp_done) begin
					cmd.op = DP_COMP_STEP;
				end else if (!sel_q && stat.is_unite) begin
					cmd.op    = DP_WALK_START;
					cmd.sel_b = 1'b1;
				end else begin
					cmd.op = DP_SIZE_A;
				end
			end
			ST_SZA:    cmd.op = DP_SIZE_B;
			ST_SZB:    cmd.op = DP_SIZE_CAP;
			ST_COMMIT: if (!stat.out_busy) cmd.op = DP_COMMIT;
			ST_ERROR:  if (!stat.out_busy) cmd.op = DP_ERROR;
			default:   cmd.op = DP_NOP;
		endcase
	end

endmodule

/* design/ufe_dp.sv */
// ----------------------------------------------------------------------------
// Union-find engine datapath
// Parent and size memories, walk registers, size compare/merge, result slot.
// ----------------------------------------------------------------------------
`include "union_find_engine_unit_defines.svh"

module ufe_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ufe_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ufe_pkg::CFG_W-1:0]        cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ufe_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                             m_tuser,
	input  ufe_pkg::dp_cmd_t                 cmd,
	output ufe_pkg::dp_stat_t                stat
);
	import ufe_pkg::*;

	logic [CFG_W-1:0]   cfg_q;
	logic [INDEX_W-1:0] clr_q;
	logic               op_q;
	logic [INDEX_W-1:0] a_q, b_q;
	logic [INDEX_W-1:0] r_q, cur_q, ra_q, rb_q;
	logic [COUNT_W-1:0] sa_q, sb_q;

	logic               m_tvalid_q;
	logic [INDEX_W-1:0] out_root_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_merged_q, out_err_q;

	logic               p_we, s_we;
	logic [INDEX_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
	logic [INDEX_W-1:0] s_waddr, s_raddr;
	logic [COUNT_W-1:0] s_wdata, s_rdata;

	logic [INDEX_W-1:0] x_sel, big, sml;
	logic [COUNT_W:0]   sum;
	logic               do_merge;

	assign cfg_ready = 1'b1;
	assign x_sel     = cmd.sel_b ? b_q : a_q;
	assign do_merge  = (op_q == OP_UNITE) && (ra_q != rb_q);
	assign big       = (sa_q < sb_q) ? rb_q : ra_q;
	assign sml       = (sa_q < sb_q) ? ra_q : rb_q;
	assign sum       = {1'b0, sa_q} + {1'b0, sb_q};

	ufe_ram #(.WIDTH(INDEX_W), .DEPTH(MAX_ELEMENTS)) u_parent (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	ufe_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ELEMENTS)) u_size (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	always_comb begin
		p_we    = 1'b0;
		p_waddr = clr_q;
		p_wdata = clr_q;
		p_raddr = r_q;
		s_we    = 1'b0;
		s_waddr = clr_q;
		s_wdata = COUNT_W'(1);
		s_raddr = ra_q;
		unique case (cmd.op)
			DP_CLEAR: begin
				p_we = 1'b1;
				s_we = 1'b1;
			end
			DP_WALK_START, DP_COMP_START: p_raddr = x_sel;
			DP_WALK_STEP:                 p_raddr = p_rdata;
			DP_COMP_STEP: begin
				p_we    = 1'b1;
				p_waddr = cur_q;
				p_wdata = r_q;
				p_raddr = p_rdata;
			end
			DP_SIZE_A: s_raddr = ra_q;
			DP_SIZE_B: s_raddr = rb_q;
			DP_COMMIT: begin
				p_we    = do_merge;
				p_waddr = sml;
				p_wdata = big;
				s_we    = do_merge;
				s_waddr = big;
				s_wdata = sum[COUNT_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= CFG_W'(MAX_ELEMENTS);
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) cfg_q <= cfg_data;
			if (cmd.op == DP_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd.op == DP_COMMIT || cmd.op == DP_ERROR) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				op_q <= s_tuser;
				a_q  <= s_tdata[INDEX_W-1:0];
				b_q  <= s_tdata[2*INDEX_W-1:INDEX_W];
			end
			DP_WALK_START: r_q <= x_sel;
			DP_WALK_STEP:  r_q <= p_rdata;
			DP_COMP_START: begin
				cur_q <= x_sel;
				if (cmd.sel_b) rb_q <= r_q;
				else ra_q <= r_q;
			end
			DP_COMP_STEP:  cur_q <= p_rdata;
			DP_SIZE_B:     sa_q <= s_rdata;
			DP_SIZE_CAP:   sb_q <= s_rdata;
			DP_COMMIT: begin
				out_err_q    <= 1'b0;
				out_merged_q <= do_merge;
				out_root_q   <= do_merge ? big : ra_q;
				out_count_q  <= do_merge ? sum[COUNT_W-1:0] : sa_q;
			end
			DP_ERROR: begin
				out_err_q    <= 1'b1;
				out_merged_q <= 1'b0;
				out_root_q   <= '0;
				out_count_q  <= '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.clear_last = (clr_q == INDEX_W'(MAX_ELEMENTS - 1));
		stat.in_range   = ({{(CFG_W-INDEX_W){1'b0}}, a_q} < cfg_q)
			&& ((op_q != OP_UNITE) || ({{(CFG_W-INDEX_W){1'b0}}, b_q} < cfg_q));
		stat.is_unite   = (op_q == OP_UNITE);
		stat.root_found = (p_rdata == r_q);
		stat.comp_done  = (cur_q == r_q);
		stat.out_busy   = m_tvalid_q && !m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-INDEX_W-COUNT_W-1){1'b0}},
		out_merged_q, out_count_q, out_root_q};
	assign m_tuser  = out_err_q;

	`UFE_ASSERT_IMP(a_slot_free, (cmd.op == DP_COMMIT || cmd.op == DP_ERROR), !stat.out_busy, "result slot overwritten")
	`UFE_ASSERT_IMP(a_merge_cnt, (m_tvalid_q && out_merged_q), (out_count_q >= COUNT_W'(2)), "merged set smaller than two")
	`UFE_ASSERT_IMP(a_err_zero, (m_tvalid_q && out_err_q), (out_root_q == '0 && out_count_q == '0 && !out_merged_q), "error beat carries data")
	`UFE_ASSERT_NXT(a_clr_write, (cmd.op == DP_CLEAR && !stat.clear_last), (clr_q != '0), "clear sweep stalled")

endmodule

/* design/union_find_engine_unit.sv */
// ----------------------------------------------------------------------------
// Union-find engine
// Disjoint-set table, union by size with full path compression.
// Steps: walk to the root and compress the path for elem_a, and for elem_b on
// unite; then read both set sizes and commit; a rejected index gives an error beat.
// One item in work at a time; the next beat is taken while a result waits.
// Root walks and path compression step through the parent memory, one link per cycle.
// Reset: clearing sweep of all 1024 entries of both memories, no item taken meanwhile.
// ----------------------------------------------------------------------------
module union_find_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ufe_pkg::S_TDATA_W-1:0] s_tdata,  // elem_a, elem_b
	input  logic                          s_tuser,  // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ufe_pkg::M_TDATA_W-1:0] m_tdata,  // root_index, set_count, merged
	output logic                          m_tuser,  // index_error
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ufe_pkg::CFG_W-1:0]     cfg_data  // elements_in_use
);
	import ufe_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ufe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	ufe_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cmd(cmd), .stat(stat)
	);

endmodule
